// ===== sv/alsdf_pkg.sv =====
// Shared opcode codes, status codes, result type and formatting helpers.
package alsdf_pkg;

  localparam int OpWidth    = 5;
  localparam int DataWidth  = 64;
  localparam int BytesWidth = 4;

  typedef logic [OpWidth-1:0]    op_t;
  typedef logic [DataWidth-1:0]  data_t;
  typedef logic [BytesWidth-1:0] bytes_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_UNSUPPORTED = 2'd1,
    STATUS_INVALID     = 2'd2
  } status_t;

  // Opcode indexes in the order the load/store path presents them.
  localparam op_t OP_LDBU  = 5'd0;
  localparam op_t OP_STB   = 5'd1;
  localparam op_t OP_LDWU  = 5'd2;
  localparam op_t OP_STW   = 5'd3;
  localparam op_t OP_LDL   = 5'd4;
  localparam op_t OP_LDL_L = 5'd5;
  localparam op_t OP_STL   = 5'd6;
  localparam op_t OP_STL_C = 5'd7;
  localparam op_t OP_LDF   = 5'd8;
  localparam op_t OP_LDS   = 5'd9;
  localparam op_t OP_STF   = 5'd10;
  localparam op_t OP_STS   = 5'd11;
  localparam op_t OP_LDQ   = 5'd12;
  localparam op_t OP_LDG   = 5'd18;
  localparam op_t OP_LDT   = 5'd19;
  localparam op_t OP_STG   = 5'd20;
  localparam op_t OP_STT   = 5'd21;
  localparam op_t OP_COUNT = 5'd22;

  localparam logic MODE_MEM_TO_REG = 1'b0;
  localparam logic MODE_REG_TO_MEM = 1'b1;

  typedef struct packed {
    data_t   data;
    bytes_t  access_bytes;
    logic    is_float;
    status_t status;
  } result_t;

  // S-float memory word to T-format register layout.
  function automatic data_t expand_s(input logic [31:0] w);
    logic [6:0]  bits;
    logic [10:0] expo;
    bits = w[29:23];
    if (w[30]) begin
      expo = (bits == 7'h7f) ? 11'h7ff : {4'b1000, bits};
    end else begin
      expo = (bits == 7'h00) ? 11'h000 : {4'b0111, bits};
    end
    return {w[31], expo, w[22:0], 29'b0};
  endfunction

  // T-format register to S-float memory word, sign-extended.
  function automatic data_t pack_s(input data_t r);
    logic [31:0] w;
    w = {r[63:62], r[58:29]};
    return {{32{w[31]}}, w};
  endfunction

endpackage

// ===== sv/alsdf_format.sv =====
// Combinational formatter: one opcode/direction/value to one result.
module alsdf_format
  import alsdf_pkg::*;
(
  input  op_t     op,
  input  logic    mode,
  input  data_t   data_in,
  output result_t result
);

  logic is_fg;
  logic is_long;
  logic is_sfloat;

  assign is_fg     = (op == OP_LDF) || (op == OP_STF) || (op == OP_LDG) || (op == OP_STG);
  assign is_long   = (op >= OP_LDL) && (op <= OP_STL_C);
  assign is_sfloat = (op == OP_LDS) || (op == OP_STS);

  always_comb begin
    result.data     = data_in;
    result.status   = STATUS_OK;
    result.is_float = is_fg || is_sfloat || (op == OP_LDT) || (op == OP_STT);

    if (op <= OP_STB) begin
      result.access_bytes = 4'd1;
    end else if (op <= OP_STW) begin
      result.access_bytes = 4'd2;
    end else if (op <= OP_STS) begin
      result.access_bytes = 4'd4;
    end else if (op < OP_COUNT) begin
      result.access_bytes = 4'd8;
    end else begin
      result.access_bytes = 4'd0;
    end

    if (op >= OP_COUNT) begin
      result.status = STATUS_INVALID;
    end else if (is_fg) begin
      result.status = STATUS_UNSUPPORTED;
    end else if (is_long) begin
      result.data = (mode == MODE_REG_TO_MEM) ? {32'b0, data_in[31:0]}
                                              : {{32{data_in[31]}}, data_in[31:0]};
    end else if (is_sfloat) begin
      result.data = (mode == MODE_REG_TO_MEM) ? pack_s(data_in) : expand_s(data_in[31:0]);
    end
  end

endmodule

// ===== sv/alpha_load_store_data_formatter.sv =====
// Alpha load/store data formatter: input register, formatter, result register.
// Path: a word is held in the input register, then in the result register, where
//   out_valid presents it.
// Throughput: one word per cycle; the two-register pipeline advances whenever
//   the result register is empty or being drained, so words flow back to back.
// Reset (rst, synchronous, active high) clears both valid flags; payload
//   registers are not reset.
module alpha_load_store_data_formatter
  import alsdf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  // input channel
  input  logic    in_valid,
  output logic    in_ready,
  input  op_t     op,
  input  logic    mode,
  input  data_t   data_in,
  // result channel
  output logic    out_valid,
  input  logic    out_ready,
  output data_t   data_out,
  output bytes_t  access_bytes,
  output logic    is_float,
  output status_t status
);

  // Input register stage.
  logic    s1_valid;
  op_t     s1_op;
  logic    s1_mode;
  data_t   s1_data;

  // Result register stage handshake.
  logic    s2_ready;
  result_t fmt_result;
  result_t res;

  // Result register takes a word when empty or being drained this cycle.
  assign s2_ready = !out_valid || out_ready;
  // Input register frees up when its word moves to the result register.
  assign in_ready = !s1_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op   <= op;
      s1_mode <= mode;
      s1_data <= data_in;
    end
  end

  // All formatting is pure bit logic between the two registers.
  alsdf_format u_format (
    .op      (s1_op),
    .mode    (s1_mode),
    .data_in (s1_data),
    .result  (fmt_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      res <= fmt_result;
    end
  end

  assign data_out     = res.data;
  assign access_bytes = res.access_bytes;
  assign is_float     = res.is_float;
  assign status       = res.status;

endmodule
